// File: rtl/core/goc_pkg.sv
// Shared types, constants and tables for the GNSS obstruction classifier.
// Used by goc_mul, goc_rules and gnss_obstruction_classifier; no dependencies.
package goc_pkg;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int FIELD_TIME_W    = 32;
  localparam int IN_DATA_WIDTH   = 96;
  localparam int OUT_DATA_WIDTH  = 96;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int COUNT_WIDTH     = 32;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANALYSIS_INTERVAL = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DETECT_THRESHOLD  = 2'd1;

  localparam logic [15:0] INTERVAL_RESET  = 16'd30;
  localparam logic [3:0]  THRESHOLD_RESET = 4'd5;

  // Shared multiplier operand and product widths
  localparam int MUL_WIDTH  = 20;
  localparam int PROD_WIDTH = 2 * MUL_WIDTH;
  localparam int FACT_WIDTH = 17;

  localparam logic [FACT_WIDTH-1:0] ONE_Q16 = 17'd65536;

  // Accuracy factor: (1000 - acc) / 1000, reciprocal scaled by 2^ACC_SHIFT
  localparam logic [15:0] ACC_FULL_DM = 16'd1000;
  localparam int ACC_SHIFT = 10;
  localparam logic [FACT_WIDTH-1:0] ACC_RECIP =
    17'((64'd65536 << ACC_SHIFT) / 64'd1000);

  // Age factor: (300 - age) / 300, reciprocal scaled by 2^AGE_SHIFT
  localparam int AGE_FULL_S = 300;
  localparam int AGE_SHIFT = 9;
  localparam logic [FACT_WIDTH-1:0] AGE_RECIP =
    17'((64'd65536 << AGE_SHIFT) / 64'd300);

  typedef enum logic [3:0] {
    KIND_NONE     = 4'd0,
    KIND_INDOOR   = 4'd1,
    KIND_CANYON   = 4'd2,
    KIND_MULTIPATH = 4'd3,
    KIND_WEATHER  = 4'd4,
    KIND_BUILDING = 4'd5,
    KIND_TUNNEL   = 4'd6,
    KIND_FOREST   = 4'd7,
    KIND_MOUNTAIN = 4'd8,
    KIND_VEHICLE  = 4'd9
  } obst_kind_t;

  typedef struct packed {
    obst_kind_t  kind;
    logic [3:0]  conf;
  } verdict_t;

  // Satellite factor: min(sats,12) / 12 in Q1.16, truncated
  function automatic logic [FACT_WIDTH-1:0] sat_factor(input logic [5:0] sats);
    logic [FACT_WIDTH-1:0] f;
    case (sats)
      6'd0:  f = 17'd0;
      6'd1:  f = 17'd5461;
      6'd2:  f = 17'd10922;
      6'd3:  f = 17'd16384;
      6'd4:  f = 17'd21845;
      6'd5:  f = 17'd27306;
      6'd6:  f = 17'd32768;
      6'd7:  f = 17'd38229;
      6'd8:  f = 17'd43690;
      6'd9:  f = 17'd49152;
      6'd10: f = 17'd54613;
      6'd11: f = 17'd60074;
      default: f = ONE_Q16;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/core/goc_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on goc_pkg for operand and product widths.
module goc_mul (
  input  logic                            clk,
  input  logic                            en,
  input  logic [goc_pkg::MUL_WIDTH-1:0]   a,
  input  logic [goc_pkg::MUL_WIDTH-1:0]   b,
  output logic [goc_pkg::PROD_WIDTH-1:0]  prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= goc_pkg::PROD_WIDTH'(a) * goc_pkg::PROD_WIDTH'(b);
    end
  end

endmodule

// File: rtl/core/goc_rules.sv
// Prioritized obstruction rule cascade: picks a kind and a confidence.
// Depends on goc_pkg for the kind codes and the verdict struct.
module goc_rules (
  input  logic [5:0]         sat_count,
  input  logic [15:0]        accuracy_dm,
  input  logic signed [4:0]  fix_kind,
  input  logic [15:0]        quality,
  output goc_pkg::verdict_t  verdict
);

  // Accuracy thresholds are in decimeters
  always_comb begin
    if (sat_count < 6'd4) begin
      verdict = '{kind: goc_pkg::KIND_INDOOR, conf: 4'd8};
    end else if (sat_count < 6'd8 && accuracy_dm > 16'd500) begin
      verdict = '{kind: goc_pkg::KIND_CANYON, conf: 4'd7};
    end else if (accuracy_dm > 16'd250 && sat_count >= 6'd6) begin
      verdict = '{kind: goc_pkg::KIND_MULTIPATH, conf: 4'd6};
    end else if (quality < 16'd32768 && sat_count >= 6'd8) begin
      verdict = '{kind: goc_pkg::KIND_WEATHER, conf: 4'd5};
    end else if (accuracy_dm > 16'd1000 && sat_count < 6'd6) begin
      verdict = '{kind: goc_pkg::KIND_BUILDING, conf: 4'd6};
    end else if (sat_count == 6'd0 || fix_kind == 5'sd0) begin
      verdict = '{kind: goc_pkg::KIND_TUNNEL, conf: 4'd9};
    end else if (accuracy_dm > 16'd750 && sat_count < 6'd8) begin
      verdict = '{kind: goc_pkg::KIND_FOREST, conf: 4'd5};
    end else if (accuracy_dm > 16'd1500 && sat_count >= 6'd6) begin
      verdict = '{kind: goc_pkg::KIND_MOUNTAIN, conf: 4'd4};
    end else if (accuracy_dm > 16'd500 && sat_count >= 6'd8) begin
      verdict = '{kind: goc_pkg::KIND_VEHICLE, conf: 4'd3};
    end else begin
      verdict = '{kind: goc_pkg::KIND_NONE, conf: 4'd0};
    end
  end

endmodule

// File: rtl/core/gnss_obstruction_classifier.sv
// Top level of the GNSS obstruction classifier: sequencer, state, ports.
// Depends on goc_pkg, goc_mul and goc_rules.
//
// Usage:
//   s_axis carries one fix report per transaction; m_axis returns exactly
//   one result per report. cfg_wen/cfg_index/cfg_data write the analysis
//   interval (index 0) and detect threshold (index 1); write only while idle.
//   Each report runs through a sequencer that drives one shared multiplier
//   for eight steps: two reciprocal multiplies with correction for the
//   accuracy and age factors, then the three-product quality chain and the
//   clamp. A final step applies the interval gate and the rule cascade.
//   A new report is accepted only in idle, after the previous result has
//   been written to the output register.
//   When the receiver stalls, the result stays in the output register; the
//   next report may be accepted and computed, and it waits in its final
//   step until the output register frees.
//   Reset (rst, synchronous) clears the last analysis time, both counters
//   and the obstructed flag, and loads interval 30 and threshold 5.
module gnss_obstruction_classifier #(
  parameter int TIME_WIDTH = goc_pkg::TIME_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // fields from bit 0: now_seconds(32) force_now(1) sat_count(6)
  // accuracy_dm(16) fix_kind(5) fix_time(32), zero pad
  input  logic [goc_pkg::IN_DATA_WIDTH-1:0]     s_axis_tdata,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // fields from bit 0: analysed(1) obstruction_kind(4) confidence_tenths(4)
  // quality_q16(16) obstructed(1) analyses_total(32) detections_total(32),
  // zero pad
  output logic [goc_pkg::OUT_DATA_WIDTH-1:0]    m_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  cfg_wen,
  input  logic [goc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [goc_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

  localparam int MW = goc_pkg::MUL_WIDTH;
  localparam int PW = goc_pkg::PROD_WIDTH;
  localparam int FW = goc_pkg::FACT_WIDTH;
  localparam int CW = goc_pkg::COUNT_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_EST,
    ST_ACC_CHK,
    ST_AGE_EST,
    ST_AGE_CHK,
    ST_Q_ACC,
    ST_Q_FIX,
    ST_Q_AGE,
    ST_Q_CLAMP,
    ST_FINISH
  } state_t;

  state_t state;

  // Captured report
  logic [TIME_WIDTH-1:0] now_r;
  logic [TIME_WIDTH-1:0] ftime_r;
  logic                  force_r;
  logic [5:0]            sat_r;
  logic [15:0]           acc_r;
  logic signed [4:0]     fix_r;

  // Configuration and persistent state
  logic [15:0]           interval;
  logic [3:0]            threshold;
  logic [TIME_WIDTH-1:0] last_time;
  logic [CW-1:0]         ana_cnt;
  logic [CW-1:0]         det_cnt;
  logic                  det_flag;

  // Work registers of the sequence
  logic                  age_full;
  logic                  age_zero;
  logic [8:0]            age_x;
  logic [FW-1:0]         acc_est;
  logic [FW-1:0]         age_est;
  logic [FW-1:0]         f_acc;
  logic [FW-1:0]         f_age;
  logic [15:0]           quality;

  // Shared multiplier
  logic                  mul_en;
  logic [MW-1:0]         mul_a;
  logic [MW-1:0]         mul_b;
  logic [PW-1:0]         prod;

  goc_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  goc_pkg::verdict_t verdict;

  goc_rules u_rules (
    .sat_count   (sat_r),
    .accuracy_dm (acc_r),
    .fix_kind    (fix_r),
    .quality     (quality),
    .verdict     (verdict)
  );

  // Factor helpers
  logic [9:0]            acc_x;
  logic [TIME_WIDTH-1:0] age_diff;
  logic [FW-1:0]         est_acc_now;
  logic [FW-1:0]         est_age_now;
  logic [PW-1:0]         acc_num;
  logic [PW-1:0]         age_num;
  logic [FW-1:0]         f_sat;
  logic [18:0]           f_fix;
  logic [FW-1:0]         f_acc_next;
  logic [FW-1:0]         f_age_next;
  logic [19:0]           q_final;

  assign acc_x       = 10'(goc_pkg::ACC_FULL_DM - acc_r);
  assign age_diff    = now_r - ftime_r;
  assign est_acc_now = prod[goc_pkg::ACC_SHIFT +: FW];
  assign est_age_now = prod[goc_pkg::AGE_SHIFT +: FW];
  assign acc_num     = PW'({acc_x, 16'h0000});
  assign age_num     = PW'({age_x, 16'h0000});
  assign f_sat       = goc_pkg::sat_factor(sat_r);
  assign f_fix       = fix_r[4] ? 19'(goc_pkg::ONE_Q16) : {fix_r[3:0], 15'h0000};
  assign q_final     = prod[16 +: 20];

  // Reciprocal estimate is at most one low; bump it when (est+1)*C still fits
  always_comb begin
    if (acc_r == 16'd0) begin
      f_acc_next = goc_pkg::ONE_Q16;
    end else if (acc_r >= goc_pkg::ACC_FULL_DM) begin
      f_acc_next = '0;
    end else if (acc_num >= prod) begin
      f_acc_next = FW'(acc_est + FW'(1));
    end else begin
      f_acc_next = acc_est;
    end
  end

  always_comb begin
    if (age_full) begin
      f_age_next = goc_pkg::ONE_Q16;
    end else if (age_zero) begin
      f_age_next = '0;
    end else if (age_num >= prod) begin
      f_age_next = FW'(age_est + FW'(1));
    end else begin
      f_age_next = age_est;
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      ST_ACC_EST: begin
        mul_a = MW'(acc_x);
        mul_b = MW'(goc_pkg::ACC_RECIP);
      end
      ST_ACC_CHK: begin
        mul_a = MW'(FW'(est_acc_now + FW'(1)));
        mul_b = MW'(goc_pkg::ACC_FULL_DM);
      end
      ST_AGE_EST: begin
        mul_a = MW'(age_x);
        mul_b = MW'(goc_pkg::AGE_RECIP);
      end
      ST_AGE_CHK: begin
        mul_a = MW'(FW'(est_age_now + FW'(1)));
        mul_b = MW'(goc_pkg::AGE_FULL_S);
      end
      ST_Q_ACC: begin
        mul_a = MW'(f_sat);
        mul_b = MW'(f_acc);
      end
      ST_Q_FIX: begin
        mul_a = MW'(prod[16 +: 17]);
        mul_b = MW'(f_fix);
      end
      ST_Q_AGE: begin
        mul_a = MW'(prod[16 +: 19]);
        mul_b = MW'(f_age);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Interval gate and detection decision
  logic [TIME_WIDTH-1:0] last_eff;
  logic [TIME_WIDTH-1:0] gate_diff;
  logic                  pass;
  logic                  hit;
  logic                  out_free;
  logic [CW-1:0]         ana_cnt_next;
  logic [CW-1:0]         det_cnt_next;
  logic                  det_flag_next;
  logic [15:0]           q_out;
  goc_pkg::verdict_t     verdict_out;

  assign last_eff  = force_r ? '0 : last_time;
  assign gate_diff = now_r - last_eff;
  assign pass      = (now_r >= last_eff) && (gate_diff >= TIME_WIDTH'(interval));
  assign hit       = pass && (verdict.kind != goc_pkg::KIND_NONE) &&
                     (verdict.conf > threshold);
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  assign ana_cnt_next  = pass ? CW'(ana_cnt + CW'(1)) : ana_cnt;
  assign det_cnt_next  = hit ? CW'(det_cnt + CW'(1)) : det_cnt;
  assign det_flag_next = pass ? hit : det_flag;
  assign q_out         = pass ? quality : 16'h0000;
  assign verdict_out   = pass ? verdict :
                         goc_pkg::verdict_t'{kind: goc_pkg::KIND_NONE, conf: 4'd0};

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      interval      <= goc_pkg::INTERVAL_RESET;
      threshold     <= goc_pkg::THRESHOLD_RESET;
      last_time     <= '0;
      ana_cnt       <= '0;
      det_cnt       <= '0;
      det_flag      <= 1'b0;
    end else begin
      // Drop valid once taken, unless the final step refills the register now
      if (m_axis_tvalid && m_axis_tready && !(state == ST_FINISH && out_free)) begin
        m_axis_tvalid <= 1'b0;
      end

      if (cfg_wen) begin
        case (cfg_index)
          goc_pkg::CFG_ANALYSIS_INTERVAL: interval  <= cfg_data;
          goc_pkg::CFG_DETECT_THRESHOLD:  threshold <= cfg_data[3:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            now_r   <= TIME_WIDTH'(s_axis_tdata[31:0]);
            force_r <= s_axis_tdata[32];
            sat_r   <= s_axis_tdata[38:33];
            acc_r   <= s_axis_tdata[54:39];
            fix_r   <= s_axis_tdata[59:55];
            ftime_r <= TIME_WIDTH'(s_axis_tdata[91:60]);
            state   <= ST_ACC_EST;
          end
        end
        ST_ACC_EST: begin
          // Classify the fix age while the accuracy estimate multiplies
          age_full <= (ftime_r == '0) || (ftime_r >= now_r);
          age_zero <= age_diff >= TIME_WIDTH'(goc_pkg::AGE_FULL_S);
          age_x    <= 9'(TIME_WIDTH'(goc_pkg::AGE_FULL_S) - age_diff);
          state    <= ST_ACC_CHK;
        end
        ST_ACC_CHK: begin
          acc_est <= est_acc_now;
          state   <= ST_AGE_EST;
        end
        ST_AGE_EST: begin
          f_acc <= f_acc_next;
          state <= ST_AGE_CHK;
        end
        ST_AGE_CHK: begin
          age_est <= est_age_now;
          state   <= ST_Q_ACC;
        end
        ST_Q_ACC: begin
          f_age <= f_age_next;
          state <= ST_Q_FIX;
        end
        ST_Q_FIX: begin
          state <= ST_Q_AGE;
        end
        ST_Q_AGE: begin
          state <= ST_Q_CLAMP;
        end
        ST_Q_CLAMP: begin
          quality <= (q_final > 20'd65535) ? 16'hFFFF : q_final[15:0];
          state   <= ST_FINISH;
        end
        ST_FINISH: begin
          // Hold here until the output register can take the result
          if (out_free) begin
            if (pass) begin
              last_time <= now_r;
            end else if (force_r) begin
              last_time <= '0;
            end
            ana_cnt       <= ana_cnt_next;
            det_cnt       <= det_cnt_next;
            det_flag      <= det_flag_next;
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'b000000, det_cnt_next, ana_cnt_next, det_flag_next,
                              q_out, verdict_out.conf, verdict_out.kind, pass};
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A detection is always counted together with an analysis
  assert property (@(posedge clk) disable iff (rst)
    !$stable(det_cnt) |-> !$stable(ana_cnt))
    else $error("detection counted without an analysis");

  // A skipped report carries no kind, confidence or quality
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[24:1] == 24'h000000))
    else $error("skipped report carries analysis fields");

  // Leaving the final step always presents a result
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> m_axis_tvalid)
    else $error("finished report produced no result");

endmodule

// File: tb/goc_result_checker.sv
// Scoreboard for the GNSS obstruction classifier: watches the report, result
// and register-write channels, predicts every result and compares it.
// Depends on goc_pkg for port widths, register indexes and obstruction kinds.
module goc_result_checker
  import goc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // fields from bit 0: now_seconds(32) force_now(1) sat_count(6)
  // accuracy_dm(16) fix_kind(5) fix_time(32), zero pad
  input  logic [IN_DATA_WIDTH-1:0]   s_axis_tdata,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  // fields from bit 0: analysed(1) obstruction_kind(4) confidence_tenths(4)
  // quality_q16(16) obstructed(1) analyses_total(32) detections_total(32),
  // zero pad
  input  logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic                       cfg_wen,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                         failures,
  output int                         pending
);

  localparam int REPORT_BITS  = 92;
  localparam int VERDICT_BITS = 90;
  localparam int SHOWN_FAILS  = 10;

  typedef struct packed {
    logic [31:0]       fix_time;
    logic signed [4:0] fix_kind;
    logic [15:0]       accuracy_dm;
    logic [5:0]        sat_count;
    logic              force_now;
    logic [31:0]       now_seconds;
  } fix_report_t;

  typedef struct packed {
    logic [31:0] detections_total;
    logic [31:0] analyses_total;
    logic        obstructed;
    logic [15:0] quality_q16;
    logic [3:0]  confidence_tenths;
    obst_kind_t  obstruction_kind;
    logic        analysed;
  } fix_verdict_t;

  logic [31:0]  last_analysis_s  = '0;
  logic [31:0]  analyses_seen    = '0;
  logic [31:0]  detections_seen  = '0;
  logic         obstructed_now   = 1'b0;
  logic [15:0]  interval_s       = INTERVAL_RESET;
  logic [3:0]   threshold_tenths = THRESHOLD_RESET;
  fix_verdict_t expected_verdicts[$];
  int           mismatch_count   = 0;

  // Q0.16 product of the four factors, each step truncated, clamped at the end
  function automatic logic [15:0] predict_quality(input logic [31:0] now,
                                                  input logic [5:0] sats,
                                                  input logic [15:0] acc,
                                                  input logic signed [4:0] fix,
                                                  input logic [31:0] ftime);
    logic [63:0] q;
    logic [63:0] f;
    logic [63:0] age;
    q = 64'd65536;
    f = ((sats > 6'd12 ? 64'd12 : {58'd0, sats}) * 64'd65536) / 64'd12;
    q = (q * f) >> 16;
    if (acc == 16'd0) f = 64'd65536;
    else if (acc >= 16'd1000) f = 64'd0;
    else f = ((64'd1000 - {48'd0, acc}) * 64'd65536) / 64'd1000;
    q = (q * f) >> 16;
    if (fix < 0) f = 64'd65536;
    else f = {59'd0, fix} * 64'd32768;
    q = (q * f) >> 16;
    if (ftime == 32'd0 || ftime >= now) begin
      f = 64'd65536;
    end else begin
      age = {32'd0, now} - {32'd0, ftime};
      if (age >= 64'd300) f = 64'd0;
      else f = ((64'd300 - age) * 64'd65536) / 64'd300;
    end
    q = (q * f) >> 16;
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  // Rule cascade in priority order; the first matching rule wins
  function automatic obst_kind_t pick_obstruction(input logic [5:0] sats,
                                                  input logic [15:0] acc,
                                                  input logic signed [4:0] fix,
                                                  input logic [15:0] q,
                                                  output logic [3:0] conf);
    obst_kind_t kind;
    if (sats < 6'd4) begin
      kind = KIND_INDOOR;    conf = 4'd8;
    end else if (sats < 6'd8 && acc > 16'd500) begin
      kind = KIND_CANYON;    conf = 4'd7;
    end else if (acc > 16'd250 && sats >= 6'd6) begin
      kind = KIND_MULTIPATH; conf = 4'd6;
    end else if (q < 16'd32768 && sats >= 6'd8) begin
      kind = KIND_WEATHER;   conf = 4'd5;
    end else if (acc > 16'd1000 && sats < 6'd6) begin
      kind = KIND_BUILDING;  conf = 4'd6;
    end else if (sats == 6'd0 || fix == 0) begin
      kind = KIND_TUNNEL;    conf = 4'd9;
    end else if (acc > 16'd750 && sats < 6'd8) begin
      kind = KIND_FOREST;    conf = 4'd5;
    end else if (acc > 16'd1500 && sats >= 6'd6) begin
      kind = KIND_MOUNTAIN;  conf = 4'd4;
    end else if (acc > 16'd500 && sats >= 6'd8) begin
      kind = KIND_VEHICLE;   conf = 4'd3;
    end else begin
      kind = KIND_NONE;      conf = 4'd0;
    end
    return kind;
  endfunction

  // Apply the interval gate, advance the held state, return the result
  function automatic fix_verdict_t judge_report(input fix_report_t r);
    fix_verdict_t v;
    logic [3:0]   conf;
    v = '0;
    if (r.force_now) last_analysis_s = '0;
    if (r.now_seconds >= last_analysis_s &&
        (r.now_seconds - last_analysis_s) >= {16'd0, interval_s}) begin
      v.analysed = 1'b1;
      last_analysis_s = r.now_seconds;
      analyses_seen = analyses_seen + 32'd1;
      v.quality_q16 = predict_quality(r.now_seconds, r.sat_count, r.accuracy_dm,
                                      r.fix_kind, r.fix_time);
      v.obstruction_kind = pick_obstruction(r.sat_count, r.accuracy_dm, r.fix_kind,
                                            v.quality_q16, conf);
      v.confidence_tenths = conf;
      if (v.obstruction_kind != KIND_NONE && conf > threshold_tenths) begin
        obstructed_now = 1'b1;
        detections_seen = detections_seen + 32'd1;
      end else begin
        obstructed_now = 1'b0;
      end
    end
    v.obstructed = obstructed_now;
    v.analyses_total = analyses_seen;
    v.detections_total = detections_seen;
    return v;
  endfunction

  function automatic string verdict_text(input fix_verdict_t v);
    return $sformatf("analysed=%0d kind=%0d conf=%0d q=%0d obstructed=%0d an=%0d det=%0d",
                     v.analysed, v.obstruction_kind, v.confidence_tenths,
                     v.quality_q16, v.obstructed, v.analyses_total,
                     v.detections_total);
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= SHOWN_FAILS) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : watch
    fix_verdict_t seen;
    fix_verdict_t want;
    if (rst) begin
      last_analysis_s  = '0;
      analyses_seen    = '0;
      detections_seen  = '0;
      obstructed_now   = 1'b0;
      interval_s       = INTERVAL_RESET;
      threshold_tenths = THRESHOLD_RESET;
      expected_verdicts.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_ANALYSIS_INTERVAL: interval_s = cfg_data;
          CFG_DETECT_THRESHOLD:  threshold_tenths = cfg_data[3:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = fix_verdict_t'(m_axis_tdata[VERDICT_BITS-1:0]);
        if (expected_verdicts.size() == 0) begin
          note_failure({"result with nothing pending: ", verdict_text(seen)});
        end else begin
          want = expected_verdicts.pop_front();
          if (seen.analysed          !== want.analysed ||
              seen.obstruction_kind  !== want.obstruction_kind ||
              seen.confidence_tenths !== want.confidence_tenths ||
              seen.quality_q16       !== want.quality_q16 ||
              seen.obstructed        !== want.obstructed ||
              seen.analyses_total    !== want.analyses_total ||
              seen.detections_total  !== want.detections_total) begin
            note_failure({"mismatch: expected ", verdict_text(want),
                          " got ", verdict_text(seen)});
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_verdicts.push_back(
          judge_report(fix_report_t'(s_axis_tdata[REPORT_BITS-1:0])));
      end
    end
    failures <= mismatch_count;
    pending  <= expected_verdicts.size();
  end

endmodule

// File: tb/tb_gnss_obstruction_classifier.sv
// Top of the GNSS obstruction classifier testbench: clock, reset, report
// stimulus, result backpressure, register phases and the final verdict.
// Depends on goc_pkg, gnss_obstruction_classifier and goc_result_checker.
module tb_gnss_obstruction_classifier;
  import goc_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_REPORTS = 230;
  localparam int LONG_HOLD     = 300;     // receiver hold-off for the fill test
  localparam int SETTLE_CYCLES = 20;      // wait after the drain before the final verdict
  localparam int RUN_LIMIT     = 4000000; // time units, several times the worst run

  // Indexes beyond the register list; writes there must be ignored
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 2'd3;

  logic                       clk           = 1'b0;
  logic                       rst           = 1'b1;
  logic [IN_DATA_WIDTH-1:0]   s_axis_tdata  = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b1;
  logic                       cfg_wen       = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index     = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data      = '0;
  int                         failures;
  int                         pending;

  bit          quiet        = 1'b0;  // no idling on either side
  bit          hold_request = 1'b0;  // ask the receiver for one long hold-off
  bit          force_next   = 1'b0;
  logic [31:0] clock_s      = '0;    // latest report time handed out
  int          interval_now = 30;    // mirror of the programmed interval

  logic [15:0] phase_interval  [RANDOM_PHASES] = '{16'd0, 16'd1, 16'd65535,
                                                   16'd30, 16'd0, 16'd7};
  logic [3:0]  phase_threshold [RANDOM_PHASES] = '{4'd0, 4'd10, 4'd15,
                                                   4'd3, 4'd0, 4'd5};

  gnss_obstruction_classifier dut (.*);

  goc_result_checker checker_i (.*);

  always #HALF_PERIOD clk = ~clk;

  // Offer one report and hold it until the transaction completes; then
  // maybe drop valid for a random gap. The next call raises valid at a
  // later edge, or keeps it high at this one, never both.
  task automatic offer_report(input logic [31:0] now, input logic force_now,
                              input logic [5:0] sats, input logic [15:0] acc,
                              input logic signed [4:0] fix,
                              input logic [31:0] ftime);
    s_axis_tdata  <= {4'd0, ftime, fix, acc, sats, force_now, now};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every pending result has been taken
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Program both registers, then hit both spare indexes with noise
  task automatic write_regs(input logic [15:0] interval, input logic [3:0] threshold);
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_ANALYSIS_INTERVAL;
    cfg_data  <= interval;
    @(posedge clk);
    cfg_index <= CFG_DETECT_THRESHOLD;
    cfg_data  <= {12'($urandom), threshold};
    @(posedge clk);
    cfg_index <= CFG_SPARE_LO;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_index <= CFG_SPARE_HI;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Reset registers are in force here: interval 30, threshold 5
  task automatic directed_reports();
    // time zero with the last analysis at zero: gate not yet open
    offer_report(32'd0,   1'b0, 6'd0,  16'd0,     -5'sd1,  32'd0);
    offer_report(32'd30,  1'b0, 6'd3,  16'd0,     -5'sd1,  32'd0);   // indoor
    offer_report(32'd45,  1'b0, 6'd12, 16'd0,     5'sd2,   32'd0);   // skipped, flag held
    offer_report(32'd60,  1'b0, 6'd5,  16'd600,   5'sd2,   32'd0);   // urban canyon
    offer_report(32'd90,  1'b0, 6'd6,  16'd300,   5'sd1,   32'd0);   // multipath
    offer_report(32'd120, 1'b0, 6'd8,  16'd100,   5'sd1,   32'd0);   // weather, at threshold
    offer_report(32'd150, 1'b0, 6'd4,  16'd100,   5'sd0,   32'd0);   // tunnel
    offer_report(32'd180, 1'b0, 6'd12, 16'd0,     5'sd2,   32'd0);   // none, clamp
    offer_report(32'd210, 1'b0, 6'd63, 16'd0,     5'sd15,  32'd0);   // sats capped, fix max
    offer_report(32'd240, 1'b0, 6'd10, 16'd999,   -5'sd16, 32'd140); // age 100
    offer_report(32'd270, 1'b0, 6'd10, 16'd1000,  5'sd3,   32'd0);   // accuracy factor zero
    offer_report(32'd300, 1'b0, 6'd9,  16'd0,     5'sd2,   32'd1);   // age 299
    offer_report(32'd330, 1'b0, 6'd9,  16'd0,     5'sd2,   32'd30);  // age 300
    offer_report(32'd360, 1'b0, 6'd9,  16'd0,     5'sd2,   32'd400); // fix in the future
    offer_report(32'd390, 1'b0, 6'd9,  16'd0,     5'sd2,   32'd390); // fix time equals now
    // clock behind the last analysis: skipped, then forced through
    offer_report(32'd100, 1'b0, 6'd8,  16'd65535, 5'sd4,   32'd50);
    offer_report(32'd100, 1'b1, 6'd8,  16'd65535, 5'sd4,   32'd50);
    offer_report(32'd129, 1'b0, 6'd7,  16'd300,   5'sd1,   32'd0);   // one second short
    offer_report(32'hFFFF_FFFF, 1'b0, 6'd11, 16'd200, 5'sd2, 32'hFFFF_FFF0);
    offer_report(32'd5,   1'b0, 6'd11, 16'd200,   5'sd2,   32'd0);   // wrapped clock
    offer_report(32'd40,  1'b1, 6'd7,  16'd501,   5'sd1,   32'd39);
    // forced, but still inside the interval from zero
    offer_report(32'd10,  1'b1, 6'd2,  16'd0,     5'sd1,   32'd0);
    offer_report(32'hFFFF_FFFF, 1'b0, 6'd7, 16'd501, 5'sd1, 32'hFFFF_FFFF);
  endtask

  // Mostly reports that advance the clock around the interval, so the gate
  // opens often; the rest are random times and occasional forces.
  task automatic random_report();
    logic [31:0] now;
    logic [31:0] ftime;
    logic        force_now;
    logic [5:0]  sats;
    logic [15:0] acc;
    logic [4:0]  fix;
    force_now  = force_next || ($urandom_range(0, 19) == 0);
    force_next = 1'b0;
    if ($urandom_range(0, 99) < 80) begin
      case ($urandom_range(0, 9))
        0:       now = clock_s + interval_now;
        1:       now = clock_s + interval_now - 1;
        default: now = clock_s + $urandom_range(0, 2 * interval_now + 1);
      endcase
    end else begin
      now = $urandom();
    end
    if (force_now || now > clock_s) clock_s = now;
    case ($urandom_range(0, 7))
      0:       sats = 6'($urandom);
      1:       sats = 6'd0;
      default: sats = 6'($urandom_range(1, 14));
    endcase
    case ($urandom_range(0, 5))
      0:       acc = 16'd0;
      1:       acc = 16'($urandom);
      2:       acc = 16'($urandom_range(900, 1600));
      default: acc = 16'($urandom_range(1, 800));
    endcase
    fix = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0, 1:    ftime = 32'd0;
      2:       ftime = $urandom();
      3:       ftime = now + $urandom_range(0, 5);
      default: ftime = now - $urandom_range(0, 420);
    endcase
    offer_report(now, force_now, sats, acc, fix, ftime);
  endtask

  // Sender: reset, directed reports, then register phases of random reports
  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    directed_reports();
    phase_interval[4]  = 16'($urandom_range(2, 120));
    phase_threshold[4] = 4'($urandom_range(0, 10));
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // registers change only with nothing in flight
      drain();
      quiet = (p == RANDOM_PHASES - 1);
      write_regs(phase_interval[p], phase_threshold[p]);
      interval_now = int'(phase_interval[p]);
      clock_s      = $urandom();
      force_next   = 1'b1;
      for (int n = 0; n < PHASE_REPORTS; n++) begin
        // let the result side stall long enough to back up the input
        if (p == 1 && n == 40) hold_request = 1'b1;
        random_report();
      end
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end
  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure
  initial begin : watchdog
    #RUN_LIMIT;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/core/goc_pkg.sv
rtl/core/goc_mul.sv
rtl/core/goc_rules.sv
rtl/core/gnss_obstruction_classifier.sv
tb/goc_result_checker.sv
tb/tb_gnss_obstruction_classifier.sv
